@@ src/rct_pkg.sv @@
// Shared types and codes for the reference count table.
package rct_pkg;

    // Request codes carried in the req_type field.
    localparam logic [3:0] RQ_PUSH      = 4'd0;
    localparam logic [3:0] RQ_PULL_KEY  = 4'd1;
    localparam logic [3:0] RQ_PURGE_KEY = 4'd2;
    localparam logic [3:0] RQ_PULL_POS  = 4'd3;
    localparam logic [3:0] RQ_PURGE_POS = 4'd4;
    localparam logic [3:0] RQ_FIND      = 4'd5;
    localparam logic [3:0] RQ_READ      = 4'd6;
    localparam logic [3:0] RQ_CLEAR     = 4'd7;
    localparam logic [3:0] RQ_REPAIR    = 4'd8;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [31:0] key;
        logic [7:0]  position;
    } t_req_word;

    typedef struct packed {
        logic        found;
        logic [15:0] ref_count;
        logic [3:0]  found_position;
        logic [31:0] key_out;
        logic [4:0]  entries;
        logic        count_overflow;
        logic        table_full;
    } t_rsp_word;

    // Per-cell update command.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_INC,
        CELL_DEC,
        CELL_SHIFT
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } t_state;

endpackage

@@ src/rct_cell.sv @@
// One table cell: holds a key and its count, compares, and takes its neighbor's entry.
module rct_cell #(
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  rct_pkg::t_cell_op     i_op,
    input  logic [KEY_BITS-1:0]   i_cmp_key,
    input  logic [KEY_BITS-1:0]   i_next_key,
    input  logic [COUNT_BITS-1:0] i_next_count,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [COUNT_BITS-1:0] o_count,
    output logic                  o_match
);
    import rct_pkg::*;

    logic [KEY_BITS-1:0]   r_key;
    logic [COUNT_BITS-1:0] r_count;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_LOAD: begin
                r_key   <= i_cmp_key;
                r_count <= COUNT_BITS'(1);
            end
            CELL_INC: begin
                r_count <= r_count + COUNT_BITS'(1);
            end
            CELL_DEC: begin
                r_count <= r_count - COUNT_BITS'(1);
            end
            CELL_SHIFT: begin
                r_key   <= i_next_key;
                r_count <= i_next_count;
            end
            default: begin
                r_key   <= r_key;
                r_count <= r_count;
            end
        endcase
    end

    assign o_key   = r_key;
    assign o_count = r_count;
    assign o_match = (r_key == i_cmp_key);

endmodule

@@ src/reference_count_table_unit.sv @@
// Top level of the reference count table: request decode, row of cells, result register.
//
// Usage: drive a request word on i_req and raise start; it is taken at a rising
// edge where start is high and busy is low. Each request gives one result word
// on o_rsp, marked by o_valid for exactly one cycle; the receiver cannot stall.
// Timing: the cycle after acceptance compares the key against every cell at
// once and registers the addressed position (busy high). The next cycle
// updates the cells (increment, decrement, append, or a one-place shift down
// of all later cells on removal) and registers the result, which shows on
// o_rsp the cycle after, together with o_valid. A new request can be taken in
// the update cycle, while the previous result is being registered; each request
// passes through the compare stage and then the cell update.
// Reset: synchronous, active low; empties the table, clears both error
// flags and drops o_valid. Key and count storage is not reset.
// While an error flag is set, every request but repair is ignored.
module reference_count_table_unit #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  rct_pkg::t_req_word i_req,
    output logic               busy,
    output logic               o_valid,
    output rct_pkg::t_rsp_word o_rsp
);
    import rct_pkg::*;

    localparam int PW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int PCW = (CW > 8) ? CW : 8;
    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    t_state r_state, n_state;
    t_req_word r_req;
    logic [CW-1:0] r_live, n_live;
    logic r_ovf, n_ovf;
    logic r_full, n_full;
    logic r_valid;
    t_rsp_word r_rsp, n_rsp;

    logic r_hit, n_hit;
    logic [PW-1:0] r_pos, n_pos;
    logic [KEY_BITS-1:0] r_sel_key;
    logic [COUNT_BITS-1:0] r_sel_cnt;

    logic [KEY_BITS-1:0] w_key;
    logic accept;

    logic [KEY_BITS-1:0]   w_cell_key   [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] w_cell_count [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_match;
    t_cell_op w_op [TABLE_DEPTH];

    assign w_key  = KEY_BITS'(r_req.key);
    assign busy   = (r_state == ST_MATCH);
    assign accept = start && !busy;

    // Row of cells; each one takes the entry above it on a shift.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic [KEY_BITS-1:0]   w_nk;
        logic [COUNT_BITS-1:0] w_nc;
        if (g == TABLE_DEPTH - 1) begin : g_top
            assign w_nk = w_cell_key[g];
            assign w_nc = w_cell_count[g];
        end else begin : g_mid
            assign w_nk = w_cell_key[g+1];
            assign w_nc = w_cell_count[g+1];
        end
        rct_cell #(
            .KEY_BITS  (KEY_BITS),
            .COUNT_BITS(COUNT_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op[g]),
            .i_cmp_key   (w_key),
            .i_next_key  (w_nk),
            .i_next_count(w_nc),
            .o_key       (w_cell_key[g]),
            .o_count     (w_cell_count[g]),
            .o_match     (w_match[g])
        );
    end

    // Compare stage: locate the addressed live entry.
    always_comb begin
        n_hit = 1'b0;
        n_pos = '0;
        unique case (r_req.req_type)
            RQ_PUSH, RQ_PULL_KEY, RQ_PURGE_KEY, RQ_FIND: begin
                for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                    if (w_match[i] && (CW'(i) < r_live)) begin
                        n_hit = 1'b1;
                        n_pos = PW'(i);
                    end
                end
            end
            RQ_PULL_POS, RQ_PURGE_POS, RQ_READ: begin
                if (PCW'(r_req.position) < PCW'(r_live)) begin
                    n_hit = 1'b1;
                    n_pos = PW'(r_req.position);
                end
            end
            default: begin
                n_hit = 1'b0;
            end
        endcase
    end

    // Update stage: decide cell commands, table size, flags and result.
    always_comb begin
        logic do_remove;
        logic do_inc;
        logic do_dec;
        logic do_load;
        do_remove = 1'b0;
        do_inc    = 1'b0;
        do_dec    = 1'b0;
        do_load   = 1'b0;
        n_live    = r_live;
        n_ovf     = r_ovf;
        n_full    = r_full;
        n_rsp     = '0;

        if (r_req.req_type == RQ_REPAIR) begin
            n_ovf  = 1'b0;
            n_full = 1'b0;
        end else if (!r_ovf && !r_full) begin
            unique case (r_req.req_type)
                RQ_PUSH: begin
                    if (r_hit) begin
                        n_rsp.found          = 1'b1;
                        n_rsp.found_position = 4'(r_pos);
                        n_rsp.key_out        = 32'(r_sel_key);
                        if (r_sel_cnt == CountMax) begin
                            n_ovf           = 1'b1;
                            n_rsp.ref_count = 16'(r_sel_cnt);
                        end else begin
                            do_inc          = 1'b1;
                            n_rsp.ref_count = 16'(r_sel_cnt + COUNT_BITS'(1));
                        end
                    end else if (r_live >= CW'(TABLE_DEPTH)) begin
                        n_full = 1'b1;
                    end else begin
                        do_load              = 1'b1;
                        n_live               = r_live + CW'(1);
                        n_rsp.found          = 1'b1;
                        n_rsp.ref_count      = 16'd1;
                        n_rsp.found_position = 4'(r_live);
                        n_rsp.key_out        = 32'(w_key);
                    end
                end
                RQ_CLEAR: begin
                    n_live = '0;
                end
                RQ_PULL_KEY, RQ_PULL_POS: begin
                    if (r_hit) begin
                        n_rsp.found          = 1'b1;
                        n_rsp.found_position = 4'(r_pos);
                        n_rsp.key_out        = 32'(r_sel_key);
                        if (r_sel_cnt > COUNT_BITS'(1)) begin
                            do_dec          = 1'b1;
                            n_rsp.ref_count = 16'(r_sel_cnt - COUNT_BITS'(1));
                        end else begin
                            do_remove = 1'b1;
                            n_live    = r_live - CW'(1);
                        end
                    end
                end
                RQ_PURGE_KEY, RQ_PURGE_POS: begin
                    if (r_hit) begin
                        n_rsp.found          = 1'b1;
                        n_rsp.found_position = 4'(r_pos);
                        n_rsp.key_out        = 32'(r_sel_key);
                        do_remove            = 1'b1;
                        n_live               = r_live - CW'(1);
                    end
                end
                RQ_FIND, RQ_READ: begin
                    if (r_hit) begin
                        n_rsp.found          = 1'b1;
                        n_rsp.found_position = 4'(r_pos);
                        n_rsp.key_out        = 32'(r_sel_key);
                        n_rsp.ref_count      = 16'(r_sel_cnt);
                    end
                end
                default: begin
                    n_live = r_live;
                end
            endcase
        end

        n_rsp.entries        = 5'(n_live);
        n_rsp.count_overflow = n_ovf;
        n_rsp.table_full     = n_full;

        // Apply only in the update cycle; removal shifts every later cell down.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_op[i] = CELL_HOLD;
            if (r_state == ST_UPDATE) begin
                if (do_remove && (PW'(i) >= r_pos)) begin
                    w_op[i] = CELL_SHIFT;
                end else if (do_inc && (PW'(i) == r_pos)) begin
                    w_op[i] = CELL_INC;
                end else if (do_dec && (PW'(i) == r_pos)) begin
                    w_op[i] = CELL_DEC;
                end else if (do_load && (CW'(i) == r_live)) begin
                    w_op[i] = CELL_LOAD;
                end
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = start ? ST_MATCH : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_live  <= '0;
            r_ovf   <= 1'b0;
            r_full  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_UPDATE);
            if (r_state == ST_UPDATE) begin
                r_live <= n_live;
                r_ovf  <= n_ovf;
                r_full <= n_full;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (r_state == ST_MATCH) begin
            r_hit     <= n_hit;
            r_pos     <= n_pos;
            r_sel_key <= w_cell_key[n_pos];
            r_sel_cnt <= w_cell_count[n_pos];
        end
        if (r_state == ST_UPDATE) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule
